@@ src/mrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types, constants and helpers of the maxrects rectangle packer:
// rectangle record, status codes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package mrp_pkg;

    // field widths
    localparam int DIM_W  = 13;
    localparam int POS_W  = 12;
    localparam int STAT_W = 2;
    localparam int REG_W  = 13;
    localparam int IDX_W  = 1;

    // largest bin side in pixels
    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(4096);

    // default free list capacity
    localparam int MAX_FREE_DEF = 64;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_BIN_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_BIN_HEIGHT = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    // one free rectangle
    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } rect_t;

    localparam int RECT_W = $bits(rect_t);

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_NOFIT,
        S_SPLIT_RD,
        S_SPLIT_LD,
        S_SPLIT_PART,
        S_PR_RD,
        S_PR_LD,
        S_PR_SWEEP,
        S_PR_WB,
        S_SEL,
        S_SEL_END,
        S_FINISH
    } state_t;

    // datapath commands
    typedef enum logic [4:0] {
        C_NONE,
        C_LOAD,
        C_START,
        C_SCAN_INIT,
        C_SCAN,
        C_NOFIT,
        C_SPLIT_RD,
        C_SPLIT_LD,
        C_SPLIT_PART,
        C_PRUNE_INIT,
        C_PR_RD,
        C_PR_LD,
        C_PR_SWEEP,
        C_PR_WB,
        C_SEL_INIT,
        C_SEL_SWEEP,
        C_SEL_END,
        C_EMIT
    } cmd_t;

    // datapath status toward the controller
    typedef struct packed {
        logic is_place;
        logic found;
        logic sweep_done;
        logic split_end;
        logic part_last;
        logic prune_end;
        logic sel_more;
        logic out_free;
    } dp_status_t;

    // sort key: y, x, height, width
    function automatic logic [RECT_W-1:0] rect_key(input rect_t r);
        rect_key = {r.y, r.x, r.h, r.w};
    endfunction

    // true when big holds all of small
    function automatic logic encloses(input rect_t big, input rect_t small_r);
        logic [DIM_W:0] br;
        logic [DIM_W:0] bb;
        logic [DIM_W:0] sr;
        logic [DIM_W:0] sb;
        br = {1'b0, big.x} + {1'b0, big.w};
        bb = {1'b0, big.y} + {1'b0, big.h};
        sr = {1'b0, small_r.x} + {1'b0, small_r.w};
        sb = {1'b0, small_r.y} + {1'b0, small_r.h};
        encloses = (small_r.x >= big.x) && (small_r.y >= big.y) &&
                   (sr <= br) && (sb <= bb);
    endfunction

endpackage

@@ src/maxrects_rectangle_packer.sv @@
// ----------------------------------------------------------------------------
// maxrects_rectangle_packer
// MaxRects allocator with best-short-side-fit choice, one word in and one
// result word out per operation.
// ----------------------------------------------------------------------------
// One operation at a time. A place scores every free rectangle, splits
// each free rectangle into its parts, prunes the parts and emits the
// surviving rectangles in sorted order, besides accepting, decoding and
// finishing; a place that fits nowhere ends after the score. The pruning
// and sorting sweeps go through the single read port of the split scratch
// memory. The result register lets the next word be accepted while a
// result still waits.
module maxrects_rectangle_packer #(
    parameter int MAX_FREE = mrp_pkg::MAX_FREE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [mrp_pkg::DIM_W-1:0]     rect_width,
    input  logic [mrp_pkg::DIM_W-1:0]     rect_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          placed,
    output logic [mrp_pkg::POS_W-1:0]     pos_x,
    output logic [mrp_pkg::POS_W-1:0]     pos_y,
    output logic [mrp_pkg::STAT_W-1:0]    status,
    input  logic                          cfg_write,
    input  logic [mrp_pkg::IDX_W-1:0]     cfg_index,
    input  logic [mrp_pkg::REG_W-1:0]     cfg_data
);

    import mrp_pkg::*;

    cmd_t       cmd;
    dp_status_t st;

    mrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    mrp_datapath #(.MAX_FREE(MAX_FREE)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .operation   (operation),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .placed      (placed),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .status      (status)
    );

endmodule

@@ src/mrp_ram.sv @@
// ----------------------------------------------------------------------------
// mrp_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/mrp_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrp_ctrl
// Controller of the packer: sequences scan, split, prune and selection
// phases and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module mrp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mrp_pkg::dp_status_t st,
    output mrp_pkg::cmd_t      cmd
);

    import mrp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = C_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = C_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.is_place)
                begin
                    cmd        = C_SCAN_INIT;
                    state_next = S_SCAN;
                end
                else
                begin
                    cmd        = C_START;
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd = C_SCAN;
                if (st.sweep_done)
                begin
                    state_next = st.found ? S_SPLIT_RD : S_NOFIT;
                end
            end
            S_NOFIT:
            begin
                cmd        = C_NOFIT;
                state_next = S_FINISH;
            end
            S_SPLIT_RD:
            begin
                if (st.split_end)
                begin
                    cmd        = C_PRUNE_INIT;
                    state_next = S_PR_RD;
                end
                else
                begin
                    cmd        = C_SPLIT_RD;
                    state_next = S_SPLIT_LD;
                end
            end
            S_SPLIT_LD:
            begin
                cmd        = C_SPLIT_LD;
                state_next = S_SPLIT_PART;
            end
            S_SPLIT_PART:
            begin
                cmd = C_SPLIT_PART;
                if (st.part_last)
                begin
                    state_next = S_SPLIT_RD;
                end
            end
            S_PR_RD:
            begin
                if (st.prune_end)
                begin
                    cmd        = C_SEL_INIT;
                    state_next = S_SEL;
                end
                else
                begin
                    cmd        = C_PR_RD;
                    state_next = S_PR_LD;
                end
            end
            S_PR_LD:
            begin
                cmd        = C_PR_LD;
                state_next = S_PR_SWEEP;
            end
            S_PR_SWEEP:
            begin
                cmd = C_PR_SWEEP;
                if (st.sweep_done)
                begin
                    state_next = S_PR_WB;
                end
            end
            S_PR_WB:
            begin
                cmd        = C_PR_WB;
                state_next = S_PR_RD;
            end
            S_SEL:
            begin
                cmd = C_SEL_SWEEP;
                if (st.sweep_done)
                begin
                    state_next = S_SEL_END;
                end
            end
            S_SEL_END:
            begin
                cmd        = C_SEL_END;
                state_next = st.sel_more ? S_SEL : S_FINISH;
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd        = C_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/mrp_datapath.sv @@
// ----------------------------------------------------------------------------
// mrp_datapath
// Datapath of the packer: free list and split scratch memories, shared
// sweep counter, fit scoring, splitting, pruning, sorted selection and the
// result register.
// ----------------------------------------------------------------------------
module mrp_datapath #(
    parameter int MAX_FREE = mrp_pkg::MAX_FREE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mrp_pkg::cmd_t                 cmd,
    output mrp_pkg::dp_status_t           st,
    input  logic                          operation,
    input  logic [mrp_pkg::DIM_W-1:0]     rect_width,
    input  logic [mrp_pkg::DIM_W-1:0]     rect_height,
    input  logic                          cfg_write,
    input  logic [mrp_pkg::IDX_W-1:0]     cfg_index,
    input  logic [mrp_pkg::REG_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          placed,
    output logic [mrp_pkg::POS_W-1:0]     pos_x,
    output logic [mrp_pkg::POS_W-1:0]     pos_y,
    output logic [mrp_pkg::STAT_W-1:0]    status
);

    import mrp_pkg::*;

    localparam int CNT_W     = $clog2(MAX_FREE + 1);
    localparam int SCR_DEPTH = 4 * MAX_FREE;
    localparam int SCNT_W    = $clog2(SCR_DEPTH + 1);
    localparam int FA_W      = $clog2(MAX_FREE);
    localparam int SA_W      = $clog2(SCR_DEPTH);

    // control registers
    logic [DIM_W-1:0]  binw_reg, binw_next;
    logic [DIM_W-1:0]  binh_reg, binh_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SCNT_W-1:0] sw_idx_reg, sw_idx_next;
    logic              sw_pend_reg, sw_pend_next;
    logic [SCNT_W-1:0] sw_didx_reg, sw_didx_next;
    logic              found_reg, found_next;
    logic [1:0]        part_reg, part_next;
    logic [CNT_W-1:0]  split_i_reg, split_i_next;
    logic [SCNT_W-1:0] n_reg, n_next;
    logic [SCNT_W-1:0] pr_i_reg, pr_i_next;
    logic              drop_reg, drop_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic              last_v_reg, last_v_next;
    logic              have_reg, have_next;
    logic              out_valid_reg, out_valid_next;

    // payload registers
    logic              op_reg, op_next;
    logic [DIM_W-1:0]  rw_reg, rw_next;
    logic [DIM_W-1:0]  rh_reg, rh_next;
    logic [RECT_W-1:0] best_reg, best_next;
    rect_t             cur_reg, cur_next;
    rect_t             last_reg, last_next;
    rect_t             sel_reg, sel_next;
    logic              res_placed_reg, res_placed_next;
    logic [POS_W-1:0]  res_x_reg, res_x_next;
    logic [POS_W-1:0]  res_y_reg, res_y_next;
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic              out_placed_reg, out_placed_next;
    logic [POS_W-1:0]  out_x_reg, out_x_next;
    logic [POS_W-1:0]  out_y_reg, out_y_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;

    // memory ports
    logic              free_we;
    logic [FA_W-1:0]   free_waddr;
    logic [FA_W-1:0]   free_raddr;
    rect_t             free_wdata;
    logic [RECT_W-1:0] free_rdata;
    logic              scr_we;
    logic [SA_W-1:0]   scr_waddr;
    logic [SA_W-1:0]   scr_raddr;
    rect_t             scr_wdata;
    logic [RECT_W-1:0] scr_rdata;

    // working signals
    rect_t             free_rd;
    rect_t             scr_rd;
    logic [SCNT_W-1:0] sw_limit;
    logic              sw_cmd;
    logic              fits;
    logic [DIM_W-1:0]  lw, lh, sh, lg;
    logic [RECT_W-1:0] score;
    logic [DIM_W-1:0]  ux, uy;
    logic [DIM_W:0]    ur, ub, fr, fb;
    logic              ovl;
    logic              part_en;
    rect_t             part_rect;
    logic              sel_full;
    logic              cand;
    logic [DIM_W-1:0]  cfg_clamped;

    mrp_ram #(.WIDTH(RECT_W), .DEPTH(MAX_FREE)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    mrp_ram #(.WIDTH(RECT_W), .DEPTH(SCR_DEPTH)) u_scr_ram (
        .clk   (clk),
        .we    (scr_we),
        .waddr (scr_waddr),
        .wdata (scr_wdata),
        .raddr (scr_raddr),
        .rdata (scr_rdata)
    );

    assign free_rd = rect_t'(free_rdata);
    assign scr_rd  = rect_t'(scr_rdata);

    // read address selection
    assign free_raddr = (cmd == C_SCAN) ? sw_idx_reg[FA_W-1:0] : split_i_reg[FA_W-1:0];
    assign scr_raddr  = (cmd == C_PR_RD) ? pr_i_reg[SA_W-1:0] : sw_idx_reg[SA_W-1:0];

    // shared sweep bounds
    assign sw_cmd   = (cmd == C_SCAN) || (cmd == C_PR_SWEEP) || (cmd == C_SEL_SWEEP);
    assign sw_limit = (cmd == C_SCAN) ? SCNT_W'(count_reg) : n_reg;

    // fit score of the rectangle under the sweep
    always_comb
    begin
        fits  = (rw_reg != '0) && (rh_reg != '0) &&
                (rw_reg <= free_rd.w) && (rh_reg <= free_rd.h);
        lw    = free_rd.w - rw_reg;
        lh    = free_rd.h - rh_reg;
        sh    = (lw < lh) ? lw : lh;
        lg    = (lw < lh) ? lh : lw;
        score = {sh, lg, free_rd.y, free_rd.x};
    end

    // parts of the free rectangle around the placed one
    always_comb
    begin
        ux  = best_reg[DIM_W-1:0];
        uy  = best_reg[2*DIM_W-1:DIM_W];
        ur  = {1'b0, ux} + {1'b0, rw_reg};
        ub  = {1'b0, uy} + {1'b0, rh_reg};
        fr  = {1'b0, cur_reg.x} + {1'b0, cur_reg.w};
        fb  = {1'b0, cur_reg.y} + {1'b0, cur_reg.h};
        ovl = ({1'b0, cur_reg.x} < ur) && (fr > {1'b0, ux}) &&
              ({1'b0, cur_reg.y} < ub) && (fb > {1'b0, uy});
        part_rect = cur_reg;
        part_en   = 1'b0;
        unique case (part_reg)
            2'd0:
            begin
                part_en = ovl ? (uy > cur_reg.y) : 1'b1;
                if (ovl)
                begin
                    part_rect.h = uy - cur_reg.y;
                end
            end
            2'd1:
            begin
                part_en     = ovl && (ub < fb);
                part_rect.y = ub[DIM_W-1:0];
                part_rect.h = DIM_W'(fb - ub);
            end
            2'd2:
            begin
                part_en     = ovl && (ux > cur_reg.x);
                part_rect.w = ux - cur_reg.x;
            end
            2'd3:
            begin
                part_en     = ovl && (ur < fr);
                part_rect.x = ur[DIM_W-1:0];
                part_rect.w = DIM_W'(fr - ur);
            end
            default:
            begin
                part_en = 1'b0;
            end
        endcase
    end

    // selection candidate: next rectangle in sort order
    assign sel_full = (kept_reg == CNT_W'(MAX_FREE));
    assign cand = (scr_rd.w != '0) && (scr_rd.h != '0) &&
                  (!last_v_reg || (rect_key(scr_rd) > rect_key(last_reg))) &&
                  (!have_reg || (rect_key(scr_rd) < rect_key(sel_reg)));

    assign cfg_clamped = (cfg_data > MAX_DIM) ? MAX_DIM : cfg_data;

    // command decode and next values
    always_comb
    begin
        binw_next       = binw_reg;
        binh_next       = binh_reg;
        count_next      = count_reg;
        sw_idx_next     = sw_idx_reg;
        sw_pend_next    = sw_pend_reg;
        sw_didx_next    = sw_didx_reg;
        found_next      = found_reg;
        part_next       = part_reg;
        split_i_next    = split_i_reg;
        n_next          = n_reg;
        pr_i_next       = pr_i_reg;
        drop_next       = drop_reg;
        kept_next       = kept_reg;
        last_v_next     = last_v_reg;
        have_next       = have_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        rw_next         = rw_reg;
        rh_next         = rh_reg;
        best_next       = best_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        sel_next        = sel_reg;
        res_placed_next = res_placed_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_status_next = res_status_reg;
        out_placed_next = out_placed_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_status_next = out_status_reg;
        free_we         = 1'b0;
        free_waddr      = '0;
        free_wdata      = cur_reg;
        scr_we          = 1'b0;
        scr_waddr       = n_reg[SA_W-1:0];
        scr_wdata       = part_rect;

        // configuration writes
        if (cfg_write)
        begin
            if (cfg_index == REG_BIN_WIDTH)
            begin
                binw_next = cfg_clamped;
            end
            else
            begin
                binh_next = cfg_clamped;
            end
        end

        // output word taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // shared sweep counter
        if (sw_cmd)
        begin
            if (sw_idx_reg < sw_limit)
            begin
                sw_idx_next  = sw_idx_reg + SCNT_W'(1);
                sw_pend_next = 1'b1;
                sw_didx_next = sw_idx_reg;
            end
            else
            begin
                sw_pend_next = 1'b0;
            end
        end

        unique case (cmd)
            C_NONE:
            begin
            end
            C_LOAD:
            begin
                op_next = operation;
                rw_next = rect_width;
                rh_next = rect_height;
            end
            C_START:
            begin
                free_we         = 1'b1;
                free_waddr      = '0;
                free_wdata      = '{x: '0, y: '0, w: binw_reg, h: binh_reg};
                count_next      = ((binw_reg != '0) && (binh_reg != '0)) ?
                                  CNT_W'(1) : '0;
                res_placed_next = 1'b0;
                res_x_next      = '0;
                res_y_next      = '0;
                res_status_next = ST_OK;
            end
            C_SCAN_INIT:
            begin
                sw_idx_next  = '0;
                sw_pend_next = 1'b0;
                found_next   = 1'b0;
                split_i_next = '0;
                n_next       = '0;
                part_next    = '0;
            end
            C_SCAN:
            begin
                if (sw_pend_reg && fits && (!found_reg || (score < best_reg)))
                begin
                    found_next = 1'b1;
                    best_next  = score;
                end
            end
            C_NOFIT:
            begin
                res_placed_next = 1'b0;
                res_x_next      = '0;
                res_y_next      = '0;
                res_status_next = ST_NO_FIT;
            end
            C_SPLIT_RD:
            begin
            end
            C_SPLIT_LD:
            begin
                cur_next  = free_rd;
                part_next = '0;
            end
            C_SPLIT_PART:
            begin
                if (part_en)
                begin
                    scr_we = 1'b1;
                    n_next = n_reg + SCNT_W'(1);
                end
                part_next = part_reg + 2'd1;
                if (part_reg == 2'd3)
                begin
                    split_i_next = split_i_reg + CNT_W'(1);
                end
            end
            C_PRUNE_INIT:
            begin
                pr_i_next = '0;
            end
            C_PR_RD:
            begin
            end
            C_PR_LD:
            begin
                cur_next     = scr_rd;
                drop_next    = 1'b0;
                sw_idx_next  = '0;
                sw_pend_next = 1'b0;
            end
            C_PR_SWEEP:
            begin
                // drop on strict containment or on an earlier copy
                if (sw_pend_reg && (sw_didx_reg != pr_i_reg))
                begin
                    if (scr_rd == cur_reg)
                    begin
                        if (sw_didx_reg < pr_i_reg)
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    else if (encloses(scr_rd, cur_reg))
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            C_PR_WB:
            begin
                // a dropped entry is marked empty in place
                if (drop_reg)
                begin
                    scr_we      = 1'b1;
                    scr_waddr   = pr_i_reg[SA_W-1:0];
                    scr_wdata   = cur_reg;
                    scr_wdata.w = '0;
                end
                pr_i_next = pr_i_reg + SCNT_W'(1);
            end
            C_SEL_INIT:
            begin
                kept_next    = '0;
                last_v_next  = 1'b0;
                have_next    = 1'b0;
                sw_idx_next  = '0;
                sw_pend_next = 1'b0;
            end
            C_SEL_SWEEP:
            begin
                if (sw_pend_reg && cand)
                begin
                    have_next = 1'b1;
                    sel_next  = scr_rd;
                end
            end
            C_SEL_END:
            begin
                if (have_reg && !sel_full)
                begin
                    free_we      = 1'b1;
                    free_waddr   = kept_reg[FA_W-1:0];
                    free_wdata   = sel_reg;
                    kept_next    = kept_reg + CNT_W'(1);
                    last_next    = sel_reg;
                    last_v_next  = 1'b1;
                    have_next    = 1'b0;
                    sw_idx_next  = '0;
                    sw_pend_next = 1'b0;
                end
                else
                begin
                    count_next      = kept_reg;
                    res_placed_next = 1'b1;
                    res_x_next      = ux[POS_W-1:0];
                    res_y_next      = uy[POS_W-1:0];
                    res_status_next = have_reg ? ST_OVERFLOW : ST_OK;
                end
            end
            C_EMIT:
            begin
                out_valid_next  = 1'b1;
                out_placed_next = res_placed_reg;
                out_x_next      = res_x_reg;
                out_y_next      = res_y_reg;
                out_status_next = res_status_reg;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binw_reg      <= MAX_DIM;
            binh_reg      <= MAX_DIM;
            count_reg     <= '0;
            sw_idx_reg    <= '0;
            sw_pend_reg   <= 1'b0;
            sw_didx_reg   <= '0;
            found_reg     <= 1'b0;
            part_reg      <= '0;
            split_i_reg   <= '0;
            n_reg         <= '0;
            pr_i_reg      <= '0;
            drop_reg      <= 1'b0;
            kept_reg      <= '0;
            last_v_reg    <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            binw_reg      <= binw_next;
            binh_reg      <= binh_next;
            count_reg     <= count_next;
            sw_idx_reg    <= sw_idx_next;
            sw_pend_reg   <= sw_pend_next;
            sw_didx_reg   <= sw_didx_next;
            found_reg     <= found_next;
            part_reg      <= part_next;
            split_i_reg   <= split_i_next;
            n_reg         <= n_next;
            pr_i_reg      <= pr_i_next;
            drop_reg      <= drop_next;
            kept_reg      <= kept_next;
            last_v_reg    <= last_v_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        rw_reg         <= rw_next;
        rh_reg         <= rh_next;
        best_reg       <= best_next;
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        sel_reg        <= sel_next;
        res_placed_reg <= res_placed_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_status_reg <= res_status_next;
        out_placed_reg <= out_placed_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_status_reg <= out_status_next;
    end

    // status toward the controller
    always_comb
    begin
        st.is_place   = (op_reg == OP_PLACE);
        st.found      = found_reg;
        st.sweep_done = (sw_idx_reg == sw_limit) && !sw_pend_reg;
        st.split_end  = (split_i_reg == count_reg);
        st.part_last  = (part_reg == 2'd3);
        st.prune_end  = (pr_i_reg == n_reg);
        st.sel_more   = have_reg && !sel_full;
        st.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign placed    = out_placed_reg;
    assign pos_x     = out_x_reg;
    assign pos_y     = out_y_reg;
    assign status    = out_status_reg;

endmodule
